// ===== src/assert_macros.svh =====
// Assertion macros used by the framer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
// Property must hold at every rising clock edge outside reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("%m: assertion failed");
// Expression must never be true outside reset.
`define ASSERT_NEVER(label, clk, rst_n, expr) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
		else $error("%m: forbidden condition seen");
`else
`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, expr)
`endif
`endif

// ===== src/pwff_pkg.sv =====
// Package for the page window flush framer: constants, codes and types.
package pwff_pkg;

	localparam int PANEL_COLUMNS = 128;
	localparam int PANEL_PAGES   = 8;

	localparam int COL_W   = 7;
	localparam int ROW_W   = 6;
	localparam int PAGE_W  = 3;
	localparam int BYTE_W  = 8;
	localparam int INDEX_W = 3;

	localparam logic [COL_W-1:0]  COL_MAX  = COL_W'(PANEL_COLUMNS - 1);
	localparam logic [PAGE_W-1:0] PAGE_MAX = PAGE_W'(PANEL_PAGES - 1);

	// Register indexes on the write port
	localparam logic [INDEX_W-1:0] REG_FIRST_COLUMN = 3'd0;
	localparam logic [INDEX_W-1:0] REG_LAST_COLUMN  = 3'd1;
	localparam logic [INDEX_W-1:0] REG_FIRST_ROW    = 3'd2;
	localparam logic [INDEX_W-1:0] REG_LAST_ROW     = 3'd3;

	localparam logic [COL_W-1:0] RST_FIRST_COLUMN = 7'd0;
	localparam logic [COL_W-1:0] RST_LAST_COLUMN  = 7'd127;
	localparam logic [ROW_W-1:0] RST_FIRST_ROW    = 6'd0;
	localparam logic [ROW_W-1:0] RST_LAST_ROW     = 6'd63;

	// Controller command bytes
	localparam logic [BYTE_W-1:0] CMD_PAGE_START = 8'hB0;
	localparam logic [BYTE_W-1:0] CMD_LO_COLUMN  = 8'h00;
	localparam logic [BYTE_W-1:0] CMD_HI_COLUMN  = 8'h10;
	localparam logic [3:0]        NIBBLE_MASK    = 4'hF;

	// Beat of an item on the output side
	typedef enum logic [1:0] {
		BEAT_PAGE = 2'd0,
		BEAT_LO   = 2'd1,
		BEAT_HI   = 2'd2,
		BEAT_DATA = 2'd3
	} beat_t;

	typedef struct packed {
		logic [COL_W-1:0] first_column;
		logic [COL_W-1:0] last_column;
		logic [ROW_W-1:0] first_row;
		logic [ROW_W-1:0] last_row;
	} cfg_t;

	typedef struct packed {
		logic [COL_W-1:0]  col_off;
		logic [PAGE_W-1:0] page_off;
	} pos_t;

	typedef struct packed {
		logic              header;
		logic [PAGE_W-1:0] page;
		logic [COL_W-1:0]  c0;
		logic              window_done;
		pos_t              pos_nx;
	} step_t;

endpackage

// ===== src/pwff_geom.sv =====
// Window geometry: header decision, page code and next position for one byte.
module pwff_geom (
	input  pwff_pkg::cfg_t  cfg,
	input  pwff_pkg::pos_t  pos,
	output pwff_pkg::step_t step
);

	logic [pwff_pkg::COL_W-1:0]  c0, c1, col_span;
	logic [pwff_pkg::PAGE_W-1:0] p0, p1, p1_raw, page_span;
	logic                        col_last, page_last;

	always_comb begin
		// clamp to the panel, then fold reversed windows to one column / page
		c0 = (cfg.first_column > pwff_pkg::COL_MAX) ? pwff_pkg::COL_MAX : cfg.first_column;
		c1 = (cfg.last_column > pwff_pkg::COL_MAX) ? pwff_pkg::COL_MAX : cfg.last_column;
		if (c1 < c0) begin
			c1 = c0;
		end
		p0 = (cfg.first_row[pwff_pkg::ROW_W-1:3] > pwff_pkg::PAGE_MAX) ?
			pwff_pkg::PAGE_MAX : cfg.first_row[pwff_pkg::ROW_W-1:3];
		p1_raw = (cfg.last_row[pwff_pkg::ROW_W-1:3] > pwff_pkg::PAGE_MAX) ?
			pwff_pkg::PAGE_MAX : cfg.last_row[pwff_pkg::ROW_W-1:3];
		p1 = ((cfg.last_row < cfg.first_row) || (p1_raw < p0)) ? p0 : p1_raw;

		col_span  = c1 - c0;
		page_span = p1 - p0;
		// an offset at or past the span saturates to the last column / page
		col_last  = (pos.col_off >= col_span);
		page_last = (pos.page_off >= page_span);

		step.header      = (pos.col_off == '0);
		step.page        = page_last ? p1 : p0 + pos.page_off;
		step.c0          = c0;
		step.window_done = col_last && page_last;
		if (col_last) begin
			step.pos_nx.col_off  = '0;
			step.pos_nx.page_off = page_last ? '0 : pos.page_off + 1'b1;
		end else begin
			step.pos_nx.col_off  = pos.col_off + 1'b1;
			step.pos_nx.page_off = pos.page_off;
		end
	end

endmodule

// ===== src/page_window_flush_framer.sv =====
// Page window flush framer: pixel bytes in, command and data byte stream out.
// Path: a data byte passes the item register, then the result register; on a page's
//   first byte the three header commands go out first, one a cycle unless stalled.
// Throughput: one input byte per cycle inside a page while the output does not stall;
//   a page's first byte holds the input while the header goes out (single output port).
// Reset: window is the full panel, position at window start with a header pending.
`include "assert_macros.svh"

module page_window_flush_framer (
	input  logic                            clk,
	input  logic                            arst_n,
	// configuration write port
	input  logic                            wr_en,
	input  logic [pwff_pkg::INDEX_W-1:0]    wr_index,
	input  logic [pwff_pkg::COL_W-1:0]      wr_data,
	// pixel input channel
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [pwff_pkg::BYTE_W-1:0]     pixel_byte,
	// byte stream output channel
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [pwff_pkg::BYTE_W-1:0]     bus_byte,
	output logic                            is_data,
	output logic                            last_of_run,
	output logic                            window_done
);

	pwff_pkg::cfg_t  cfg_q;
	pwff_pkg::pos_t  pos_q;
	pwff_pkg::step_t step;

	// item register: one accepted pixel byte with its header context
	logic                          valid_s1;
	logic [pwff_pkg::BYTE_W-1:0]   pix_s1;
	logic [pwff_pkg::PAGE_W-1:0]   page_s1;
	logic [pwff_pkg::COL_W-1:0]    c0_s1;
	logic                          done_s1;
	pwff_pkg::beat_t               beat_q;

	// result register
	logic                          out_valid_q;
	logic [pwff_pkg::BYTE_W-1:0]   bus_byte_q;
	logic                          is_data_q;
	logic                          last_q;
	logic                          done_q;

	logic                          in_xfer, out_ready, load_out, consume;
	logic [pwff_pkg::BYTE_W-1:0]   beat_byte;

	// Configuration registers; writes to unknown indexes are dropped.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.first_column <= pwff_pkg::RST_FIRST_COLUMN;
			cfg_q.last_column  <= pwff_pkg::RST_LAST_COLUMN;
			cfg_q.first_row    <= pwff_pkg::RST_FIRST_ROW;
			cfg_q.last_row     <= pwff_pkg::RST_LAST_ROW;
		end else if (wr_en) begin
			unique case (wr_index)
				pwff_pkg::REG_FIRST_COLUMN: cfg_q.first_column <= wr_data;
				pwff_pkg::REG_LAST_COLUMN:  cfg_q.last_column  <= wr_data;
				pwff_pkg::REG_FIRST_ROW:    cfg_q.first_row    <= wr_data[pwff_pkg::ROW_W-1:0];
				pwff_pkg::REG_LAST_ROW:     cfg_q.last_row     <= wr_data[pwff_pkg::ROW_W-1:0];
				default: ;
			endcase
		end
	end

	// Geometry of the byte being accepted, from the live position.
	pwff_geom u_geom (
		.cfg  (cfg_q),
		.pos  (pos_q),
		.step (step)
	);

	// Handshake. The result register advances when empty or when its transfer
	// completes; the item register frees up on its data beat.
	assign out_ready = !out_valid_q || !out_stall;
	assign load_out  = valid_s1 && out_ready;
	assign consume   = load_out && (beat_q == pwff_pkg::BEAT_DATA);
	assign in_stall  = valid_s1 && !consume;
	assign in_xfer   = in_valid && !in_stall;

	// Position advances once per accepted byte.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (in_xfer) begin
			pos_q <= step.pos_nx;
		end
	end

	// Item register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			beat_q   <= pwff_pkg::BEAT_DATA;
		end else if (in_xfer) begin
			valid_s1 <= 1'b1;
			// a page's first byte starts with the page command
			beat_q   <= step.header ? pwff_pkg::BEAT_PAGE : pwff_pkg::BEAT_DATA;
		end else if (consume) begin
			valid_s1 <= 1'b0;
		end else if (load_out) begin
			beat_q   <= pwff_pkg::beat_t'(beat_q + 2'd1);
		end
	end

	// Item payload: no reset needed
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			pix_s1  <= pixel_byte;
			page_s1 <= step.page;
			c0_s1   <= step.c0;
			done_s1 <= step.window_done;
		end
	end

	// Byte for the current beat
	always_comb begin
		unique case (beat_q)
			pwff_pkg::BEAT_PAGE:
				beat_byte = pwff_pkg::CMD_PAGE_START |
					{{(pwff_pkg::BYTE_W-pwff_pkg::PAGE_W){1'b0}}, page_s1};
			pwff_pkg::BEAT_LO:
				beat_byte = pwff_pkg::CMD_LO_COLUMN |
					{4'h0, c0_s1[3:0] & pwff_pkg::NIBBLE_MASK};
			pwff_pkg::BEAT_HI:
				beat_byte = pwff_pkg::CMD_HI_COLUMN |
					{4'h0, {1'b0, c0_s1[pwff_pkg::COL_W-1:4]} & pwff_pkg::NIBBLE_MASK};
			pwff_pkg::BEAT_DATA:
				beat_byte = pix_s1;
			default:
				beat_byte = pix_s1;
		endcase
	end

	// Result register control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_ready) begin
			out_valid_q <= valid_s1;
		end
	end

	// Result payload: hold while stalled
	always_ff @(posedge clk) begin
		if (load_out) begin
			bus_byte_q <= beat_byte;
			is_data_q  <= (beat_q == pwff_pkg::BEAT_DATA);
			last_q     <= (beat_q == pwff_pkg::BEAT_DATA);
			done_q     <= (beat_q == pwff_pkg::BEAT_DATA) && done_s1;
		end
	end

	assign out_valid   = out_valid_q;
	assign bus_byte    = bus_byte_q;
	assign is_data     = is_data_q;
	assign last_of_run = last_q;
	assign window_done = done_q;

	// The window end only ever marks a data byte that closes its run.
	`ASSERT_CLK(a_done_on_data, clk, arst_n, out_valid && window_done |-> is_data && last_of_run)
	// A command byte is always followed by a further byte of the same run.
	`ASSERT_CLK(a_cmd_followed, clk, arst_n, out_valid && !is_data && !out_stall |=> out_valid)
	// No new transfer while a header is still going out.
	`ASSERT_CLK(a_hdr_holds_in, clk, arst_n,
		valid_s1 && (beat_q != pwff_pkg::BEAT_DATA) |-> in_stall)
	// A pending item must reach the result register when it is free.
	`ASSERT_NEVER(a_no_lost_slot, clk, arst_n, valid_s1 && !out_valid_q && !load_out)

endmodule

// ===== dv/page_window_flush_framer_tb.sv =====
// Self-checking testbench for the page window flush framer.
`timescale 1ns / 1ps

module page_window_flush_framer_tb;
	import pwff_pkg::*;

	// Run length and pacing
	localparam int CYCLE_LIMIT     = 200000;
	localparam int RANDOM_ITEMS    = 50;
	localparam int SETTLE_CYCLES   = 16;
	localparam int REPORT_LIMIT    = 10;
	localparam int HOLD_OFF_CYCLES = 150;

	// One byte on the display link, as the block should present it
	typedef struct packed {
		logic [BYTE_W-1:0] bus_byte;
		logic              is_data;
		logic              last_of_run;
		logic              window_done;
	} link_beat_t;

	logic                clk        = 1'b0;
	logic                arst_n     = 1'b0;
	logic                wr_en      = 1'b0;
	logic [INDEX_W-1:0]  wr_index   = '0;
	logic [COL_W-1:0]    wr_data    = '0;
	logic                in_valid   = 1'b0;
	logic                in_stall;
	logic [BYTE_W-1:0]   pixel_byte = '0;
	logic                out_valid;
	logic                out_stall  = 1'b0;
	logic [BYTE_W-1:0]   bus_byte;
	logic                is_data;
	logic                last_of_run;
	logic                window_done;

	page_window_flush_framer dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.wr_en       (wr_en),
		.wr_index    (wr_index),
		.wr_data     (wr_data),
		.in_valid    (in_valid),
		.in_stall    (in_stall),
		.pixel_byte  (pixel_byte),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.bus_byte    (bus_byte),
		.is_data     (is_data),
		.last_of_run (last_of_run),
		.window_done (window_done)
	);

	// Shadow of the window registers and of the flush position
	cfg_t win = '{first_column: RST_FIRST_COLUMN, last_column: RST_LAST_COLUMN,
		first_row: RST_FIRST_ROW, last_row: RST_LAST_ROW};
	pos_t pos = '0;

	// Link bytes owed by the block, oldest first
	link_beat_t link_bytes_due[$];

	// Pacing controls: a calm side never idles; a hold-off stalls the output outright
	bit tx_calm         = 1'b1;
	bit rx_calm         = 1'b1;
	int rx_hold_cycles  = 0;
	int rx_stall_left   = 0;

	int cycle_count     = 0;
	int fault_count     = 0;
	int pixels_sent     = 0;
	int bytes_checked   = 0;
	int window_writes   = 0;
	int in_hold_cycles  = 0;

	link_beat_t got_beat;
	link_beat_t due_beat;

	// 4 ns clock
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Count cycles, note input back-pressure and give up at the limit
	always @(posedge clk) begin
		cycle_count++;
		if (in_valid && in_stall)
			in_hold_cycles++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d link bytes still owed",
				cycle_count, link_bytes_due.size());
			$display("Regression FAIL");
			$finish;
		end
	end

	// Mostly no gap, sometimes a short one, now and then a long one
	function automatic int pick_gap(input bit calm);
		int r;
		if (calm)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 90)
			return $urandom_range(1, 3);
		return $urandom_range(4, 20);
	endfunction

	// Receiver: drive the output stall at the falling edge. A hold-off takes priority
	// and is counted down here, one cycle per edge.
	always @(negedge clk) begin
		if (rx_hold_cycles > 0) begin
			out_stall <= 1'b1;
			rx_hold_cycles--;
		end else if (rx_stall_left > 0) begin
			out_stall <= 1'b1;
			rx_stall_left--;
		end else begin
			out_stall <= 1'b0;
			rx_stall_left = pick_gap(rx_calm);
		end
	end

	// Checker: every output transfer must match the oldest owed byte, field by field
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			got_beat = '{bus_byte: bus_byte, is_data: is_data,
				last_of_run: last_of_run, window_done: window_done};
			if (link_bytes_due.size() == 0) begin
				fault_count++;
				if (fault_count <= REPORT_LIMIT)
					$display("%0t: unexpected byte %02h data %0b last %0b done %0b",
						$realtime, got_beat.bus_byte, got_beat.is_data,
						got_beat.last_of_run, got_beat.window_done);
			end else begin
				due_beat = link_bytes_due.pop_front();
				bytes_checked++;
				if (got_beat.bus_byte !== due_beat.bus_byte ||
						got_beat.is_data !== due_beat.is_data ||
						got_beat.last_of_run !== due_beat.last_of_run ||
						got_beat.window_done !== due_beat.window_done) begin
					fault_count++;
					if (fault_count <= REPORT_LIMIT)
						$display({"%0t: expected byte %02h data %0b last %0b done %0b,",
							" got byte %02h data %0b last %0b done %0b"},
							$realtime, due_beat.bus_byte, due_beat.is_data,
							due_beat.last_of_run, due_beat.window_done,
							got_beat.bus_byte, got_beat.is_data,
							got_beat.last_of_run, got_beat.window_done);
				end
			end
		end
	end

	// Window geometry from the shadow registers. Reversed bounds collapse the window
	// to its first column or first page; out-of-panel values saturate.
	function automatic void window_geometry(output logic [COL_W-1:0] c0, output int ncols,
			output logic [PAGE_W-1:0] p0, output int npages);
		logic [COL_W-1:0]  c1;
		logic [PAGE_W-1:0] p1;
		c0 = (win.first_column > COL_MAX) ? COL_MAX : win.first_column;
		c1 = (win.last_column > COL_MAX) ? COL_MAX : win.last_column;
		p0 = (PAGE_W'(win.first_row >> 3) > PAGE_MAX) ? PAGE_MAX : PAGE_W'(win.first_row >> 3);
		p1 = (PAGE_W'(win.last_row >> 3) > PAGE_MAX) ? PAGE_MAX : PAGE_W'(win.last_row >> 3);
		if (c1 < c0)
			c1 = c0;
		if (win.last_row < win.first_row || p1 < p0)
			p1 = p0;
		ncols  = int'(c1) - int'(c0) + 1;
		npages = int'(p1) - int'(p0) + 1;
	endfunction

	function automatic void owe_beat(input logic [BYTE_W-1:0] b, input logic data,
			input logic last, input logic done);
		link_beat_t beat;
		beat.bus_byte    = b;
		beat.is_data     = data;
		beat.last_of_run = last;
		beat.window_done = done;
		link_bytes_due.push_back(beat);
	endfunction

	// Work out the link bytes that one pixel transfer causes and advance the position.
	// An offset at or past a shrunken window saturates: the byte closes its page, or
	// the header names the window's last page.
	function automatic void frame_pixel(input logic [BYTE_W-1:0] pix);
		logic [COL_W-1:0]  c0;
		logic [PAGE_W-1:0] p0;
		logic [PAGE_W-1:0] page;
		int                ncols;
		int                npages;
		bit                col_last;
		bit                page_last;
		window_geometry(c0, ncols, p0, npages);
		page_last = int'(pos.page_off) + 1 >= npages;
		col_last  = int'(pos.col_off) + 1 >= ncols;
		page      = page_last ? PAGE_W'(int'(p0) + npages - 1) : p0 + pos.page_off;
		if (pos.col_off == '0) begin
			owe_beat(CMD_PAGE_START | BYTE_W'(page), 1'b0, 1'b0, 1'b0);
			owe_beat(CMD_LO_COLUMN | BYTE_W'(c0[3:0]), 1'b0, 1'b0, 1'b0);
			owe_beat(CMD_HI_COLUMN | BYTE_W'((c0 >> 4) & NIBBLE_MASK), 1'b0, 1'b0, 1'b0);
		end
		owe_beat(pix, 1'b1, 1'b1, col_last && page_last);
		if (col_last) begin
			pos.col_off  = '0;
			pos.page_off = page_last ? '0 : pos.page_off + 1'b1;
		end else begin
			pos.col_off = pos.col_off + 1'b1;
		end
	endfunction

	// Offer one pixel byte after an optional gap; hold it until the transfer, then
	// predict. Valid stays high after the transfer until the next call or drain.
	task automatic send_pixel(input logic [BYTE_W-1:0] pix);
		int gap;
		gap = pick_gap(tx_calm);
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid   <= 1'b1;
		pixel_byte <= pix;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		frame_pixel(pix);
		pixels_sent++;
	endtask

	// Drop valid and wait until every owed byte has gone out
	task automatic wait_idle();
		@(negedge clk);
		in_valid <= 1'b0;
		while (link_bytes_due.size() != 0)
			@(posedge clk);
	endtask

	// Write one register; mirror it in the shadow copy. Unknown indexes are ignored,
	// row registers keep only their low six bits.
	task automatic write_reg(input logic [INDEX_W-1:0] idx, input logic [COL_W-1:0] val);
		@(negedge clk);
		wr_en    <= 1'b1;
		wr_index <= idx;
		wr_data  <= val;
		@(negedge clk);
		wr_en <= 1'b0;
		case (idx)
			REG_FIRST_COLUMN: win.first_column = val;
			REG_LAST_COLUMN:  win.last_column  = val;
			REG_FIRST_ROW:    win.first_row    = val[ROW_W-1:0];
			REG_LAST_ROW:     win.last_row     = val[ROW_W-1:0];
			default: ;
		endcase
	endtask

	task automatic set_window(input logic [COL_W-1:0] fc, input logic [COL_W-1:0] lc,
			input logic [COL_W-1:0] fr, input logic [COL_W-1:0] lr);
		write_reg(REG_FIRST_COLUMN, fc);
		write_reg(REG_LAST_COLUMN, lc);
		write_reg(REG_FIRST_ROW, fr);
		write_reg(REG_LAST_ROW, lr);
		window_writes++;
	endtask

	// Reset window is the whole panel: first transfer carries the page 0 header
	task automatic test_full_panel_start();
		tx_calm = 1'b1;
		rx_calm = 1'b1;
		send_pixel(8'h00);
		send_pixel(8'hFF);
		send_pixel(8'hA5);
	endtask

	// Shrink the window under a running flush: column offset past the new width,
	// then page offset past the new height
	task automatic test_window_shrunk_mid_flush();
		wait_idle();
		write_reg(REG_LAST_COLUMN, 7'd1);
		write_reg(REG_LAST_ROW, 7'd7);
		send_pixel(8'h5A);
		wait_idle();
		set_window(7'd5, 7'd5, 7'd0, 7'd63);
		send_pixel(8'h01);
		send_pixel(8'h80);
		send_pixel(8'h3C);
		wait_idle();
		write_reg(REG_LAST_ROW, 7'd15);
		send_pixel(8'h81);
	endtask

	// Single-byte windows in opposite panel corners: every transfer closes the window
	task automatic test_panel_corners();
		wait_idle();
		rx_calm = 1'b0;
		set_window(7'd127, 7'd127, 7'd56, 7'd63);
		send_pixel(8'h00);
		send_pixel(8'hFF);
		wait_idle();
		set_window(7'd0, 7'd0, 7'd0, 7'd0);
		send_pixel(8'h7E);
	endtask

	// Reversed column and row bounds, including rows reversed inside one page
	task automatic test_reversed_window();
		wait_idle();
		tx_calm = 1'b0;
		set_window(7'd100, 7'd20, 7'd40, 7'd8);
		send_pixel(8'hC3);
		send_pixel(8'h24);
		wait_idle();
		set_window(7'd20, 7'd22, 7'd13, 7'd9);
		send_pixel(8'hAA);
		send_pixel(8'h55);
		send_pixel(8'h0F);
	endtask

	// Writes to unused indexes must change nothing; row writes drop bit six
	task automatic test_unused_index_and_row_mask();
		wait_idle();
		set_window(7'd16, 7'd16, 7'h48, 7'h50);
		for (int i = int'(REG_LAST_ROW) + 1; i < (1 << INDEX_W); i++)
			write_reg(INDEX_W'(i), 7'h7F);
		send_pixel(8'hF0);
		send_pixel(8'h11);
		send_pixel(8'hEE);
	endtask

	// Six pixel bytes, one window's worth, into a 3 x 2 page window with gaps on both sides
	task automatic test_small_window_flush();
		wait_idle();
		set_window(7'd8, 7'd10, 7'd16, 7'd31);
		for (int i = 0; i < 6; i++)
			send_pixel(BYTE_W'($urandom));
	endtask

	// Hold the output off for a long stretch while the sender keeps offering bytes,
	// so the block backs up and stalls its input
	task automatic test_output_backpressure();
		wait_idle();
		set_window(7'd32, 7'd35, 7'd8, 7'd23);
		tx_calm = 1'b1;
		rx_hold_cycles = HOLD_OFF_CYCLES;
		for (int i = 0; i < 30; i++)
			send_pixel(BYTE_W'($urandom));
	endtask

	// Random windows, mostly flushed whole; some short or broken bursts and
	// stray register writes in between
	task automatic test_random_windows();
		logic [COL_W-1:0]  c0;
		logic [PAGE_W-1:0] p0;
		int                ncols;
		int                npages;
		int                sent;
		int                pick;
		int                burst;
		int                fc;
		int                lc;
		int                fr;
		int                lr;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			wait_idle();
			tx_calm = ($urandom_range(0, 3) == 0);
			rx_calm = ($urandom_range(0, 3) == 0);
			pick = $urandom_range(0, 9);
			if (pick == 0) begin
				// corners of every register's range
				set_window($urandom_range(0, 1) ? 7'd127 : 7'd0,
					$urandom_range(0, 1) ? 7'd127 : 7'd0,
					$urandom_range(0, 1) ? 7'd63 : 7'd0,
					$urandom_range(0, 1) ? 7'd63 : 7'd0);
			end else if (pick < 8) begin
				fc = $urandom_range(0, 127);
				lc = ($urandom_range(0, 7) == 0) ? $urandom_range(0, fc)
					: fc + $urandom_range(0, 5);
				fr = $urandom_range(0, 63);
				lr = ($urandom_range(0, 7) == 0) ? $urandom_range(0, fr)
					: fr + $urandom_range(0, 20);
				set_window(COL_W'(fc), (lc > 127) ? 7'd127 : COL_W'(lc),
					COL_W'(fr), (lr > 63) ? 7'd63 : COL_W'(lr));
			end else begin
				set_window(COL_W'($urandom), COL_W'($urandom),
					COL_W'($urandom), COL_W'($urandom));
			end
			if ($urandom_range(0, 4) == 0)
				write_reg(INDEX_W'($urandom_range(int'(REG_LAST_ROW) + 1,
					(1 << INDEX_W) - 1)), COL_W'($urandom));
			window_geometry(c0, ncols, p0, npages);
			burst = ncols * npages;
			if (burst > 24 || $urandom_range(0, 4) == 0)
				burst = $urandom_range(1, 16);
			repeat (burst)
				send_pixel(BYTE_W'($urandom));
			sent += burst;
		end
	endtask

	initial begin
		repeat (6) @(negedge clk);
		arst_n <= 1'b1;

		test_full_panel_start();
		test_window_shrunk_mid_flush();
		test_panel_corners();
		test_reversed_window();
		test_unused_index_and_row_mask();
		test_small_window_flush();
		test_output_backpressure();
		test_random_windows();

		// Drain, then give the block time to show any stray output
		wait_idle();
		rx_calm = 1'b1;
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (link_bytes_due.size() != 0) begin
			fault_count += link_bytes_due.size();
			$display("%0d link bytes never arrived", link_bytes_due.size());
		end

		$display("Covered %0d pixel transfers over %0d window settings, %0d link bytes checked.",
			pixels_sent, window_writes, bytes_checked);
		$display("Input held off for %0d cycles; %0d faults seen.", in_hold_cycles, fault_count);
		if (fault_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule
